FILE: sv/ccs_pkg.sv
// ----------------------------------------------------------------------------
// ccs_pkg
// Shared widths and the command word broadcast along the sorting chain.
// ----------------------------------------------------------------------------
package ccs_pkg;

   localparam int VALUE_W    = 32;
   localparam int RANK_OUT_W = 4;

   // broadcast to every cell in the chain each cycle
   typedef struct packed {
      logic                       insert;
      logic                       shift_out;
      logic signed [VALUE_W-1:0]  value;
   } cell_cmd_type;

endpackage

FILE: sv/ccs_channels.sv
// ----------------------------------------------------------------------------
// ccs_channels
// Valid/ready channels for incoming values and for sorted results.
// ----------------------------------------------------------------------------
interface ccs_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [ccs_pkg::VALUE_W-1:0]  value;
   logic                                final_item;

   modport source (output valid, output value, output final_item, input ready);
   modport sink   (input valid, input value, input final_item, output ready);
endinterface

interface ccs_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [ccs_pkg::VALUE_W-1:0]    sorted_value;
   logic        [ccs_pkg::RANK_OUT_W-1:0] rank;
   logic                                  end_of_run;
   logic                                  overflow;

   modport source (output valid, output sorted_value, output rank, output end_of_run,
                   output overflow, input ready);
   modport sink   (input valid, input sorted_value, input rank, input end_of_run,
                   input overflow, output ready);
endinterface

FILE: sv/ccs_cell.sv
// ----------------------------------------------------------------------------
// ccs_cell
// One slot of the insertion chain: holds a value, compares it with the
// broadcast value, and takes its own, the new or a neighbour's value.
// ----------------------------------------------------------------------------
module ccs_cell (
   input  logic                                clock,
   input  logic                                reset,
   input  ccs_pkg::cell_cmd_type               cmd,
   input  logic                                left_keep,
   input  logic signed [ccs_pkg::VALUE_W-1:0]  left_value,
   input  logic                                left_valid,
   input  logic signed [ccs_pkg::VALUE_W-1:0]  right_value,
   input  logic                                right_valid,
   output logic signed [ccs_pkg::VALUE_W-1:0]  value,
   output logic                                valid,
   output logic                                keep
);

   logic signed [ccs_pkg::VALUE_W-1:0] value_ff, value_in;
   logic                               valid_ff, valid_in;

   // stored values strictly below the new one stay put, ties move right
   assign keep  = valid_ff && (value_ff < cmd.value);
   assign value = value_ff;
   assign valid = valid_ff;

   always_comb begin
      value_in = value_ff;
      valid_in = valid_ff;
      if (cmd.insert) begin
         if (!keep) begin
            if (left_keep) begin
               value_in = cmd.value;
               valid_in = 1'b1;
            end else begin
               value_in = left_value;
               valid_in = left_valid;
            end
         end
      end else if (cmd.shift_out) begin
         value_in = right_value;
         valid_in = right_valid;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

endmodule

FILE: sv/comparison_counting_sort_top.sv
// ----------------------------------------------------------------------------
// comparison_counting_sort_top
// Streaming sorter for signed 32-bit values. Values enter one per cycle
// while a set is loading: the new value is compared in every cell of the
// chain at once and slotted in ahead of all stored values not less than it,
// so equal values come out with the later arrival first. The word marked
// final_item closes the set; from the next cycle the chain shifts towards
// cell 0 and gives one result per cycle while rsp ready is high, ascending,
// with end_of_run on the greatest value. No request is taken during that
// burst. Values beyond MAX_ITEMS are dropped and every result of that set
// carries overflow.
// ----------------------------------------------------------------------------
module comparison_counting_sort_top #(
   parameter int MAX_ITEMS = 16
) (
   input  logic      clock,
   input  logic      reset,
   ccs_req_if.sink   req_bus,
   ccs_rsp_if.source rsp_bus
);

   localparam int CntW  = $clog2(MAX_ITEMS + 1);
   localparam int RankW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;

   typedef enum logic {LOAD, UNLOAD} state_type;

   state_type              state_ff, state_in;
   logic [CntW-1:0]        count_ff, count_in;
   logic [RankW-1:0]       rank_ff, rank_in;
   logic                   dropped_ff, dropped_in;

   logic                   req_take, rsp_take, full;
   ccs_pkg::cell_cmd_type  cmd;

   logic signed [ccs_pkg::VALUE_W-1:0] cell_value [MAX_ITEMS];
   logic                               cell_valid [MAX_ITEMS];
   logic                               cell_keep  [MAX_ITEMS];
   logic [RankW+3:0]                   rank_wide;

   assign full     = (count_ff == CntW'(MAX_ITEMS));
   assign req_take = req_bus.valid && req_bus.ready;
   assign rsp_take = rsp_bus.valid && rsp_bus.ready;

   assign cmd.insert    = req_take && !full;
   assign cmd.shift_out = rsp_take;
   assign cmd.value     = req_bus.value;

   for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
      logic                               l_keep, l_valid, r_valid;
      logic signed [ccs_pkg::VALUE_W-1:0] l_value, r_value;
      if (i == 0) begin : g_first
         assign l_keep  = 1'b1;
         assign l_value = '0;
         assign l_valid = 1'b0;
      end else begin : g_mid
         assign l_keep  = cell_keep[i-1];
         assign l_value = cell_value[i-1];
         assign l_valid = cell_valid[i-1];
      end
      if (i == MAX_ITEMS - 1) begin : g_last
         assign r_value = '0;
         assign r_valid = 1'b0;
      end else begin : g_inner
         assign r_value = cell_value[i+1];
         assign r_valid = cell_valid[i+1];
      end
      ccs_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .cmd         (cmd),
         .left_keep   (l_keep),
         .left_value  (l_value),
         .left_valid  (l_valid),
         .right_value (r_value),
         .right_valid (r_valid),
         .value       (cell_value[i]),
         .valid       (cell_valid[i]),
         .keep        (cell_keep[i])
      );
   end

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      rank_in    = rank_ff;
      dropped_in = dropped_ff;
      case (state_ff)
         LOAD: begin
            if (req_take) begin
               if (full) begin
                  dropped_in = 1'b1;
               end else begin
                  count_in = count_ff + CntW'(1);
               end
               if (req_bus.final_item) begin
                  state_in = UNLOAD;
               end
            end
         end
         UNLOAD: begin
            if (rsp_take) begin
               count_in = count_ff - CntW'(1);
               rank_in  = rank_ff + RankW'(1);
               if (count_ff == CntW'(1)) begin
                  state_in   = LOAD;
                  rank_in    = '0;
                  dropped_in = 1'b0;
               end
            end
         end
         default: begin
            state_in = LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= LOAD;
         count_ff   <= '0;
         rank_ff    <= '0;
         dropped_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         rank_ff    <= rank_in;
         dropped_ff <= dropped_in;
      end
   end

   assign rank_wide = {4'b0000, rank_ff};

   assign req_bus.ready        = (state_ff == LOAD);
   assign rsp_bus.valid        = (state_ff == UNLOAD);
   assign rsp_bus.sorted_value = cell_value[0];
   assign rsp_bus.rank         = rank_wide[3:0];
   assign rsp_bus.end_of_run   = (count_ff == CntW'(1));
   assign rsp_bus.overflow     = dropped_ff;

   // a result on offer always comes from a filled head cell
   a_head_filled : assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> cell_valid[0])
      else $error("result offered from an empty head cell");

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(MAX_ITEMS))
      else $error("fill count above capacity");

   a_final_unload : assert property (@(posedge clock) disable iff (reset)
      (req_take && req_bus.final_item) |=> (state_ff == UNLOAD))
      else $error("final word did not start the output burst");

   a_drop_when_full : assert property (@(posedge clock) disable iff (reset)
      $rose(dropped_ff) |-> $past(full))
      else $error("overflow raised with room left");

   // head cell is filled whenever the count shows stored values
   a_packed : assert property (@(posedge clock) disable iff (reset)
      (count_ff != '0) |-> cell_valid[0])
      else $error("chain head empty while values are stored");

endmodule
